>>> rtl/resp_command_tokenizer_unit_macros.svh
// ---------------------------------------------------------------------------
// resp_command_tokenizer_unit_macros.svh
// assertion helpers for the command tokenizer
// ---------------------------------------------------------------------------
`ifndef RESP_COMMAND_TOKENIZER_UNIT_MACROS_SVH
`define RESP_COMMAND_TOKENIZER_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define RCT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rct_pkg.sv
// ---------------------------------------------------------------------------
// rct_pkg
// shared types, codes and number parsing helpers of the command tokenizer
// ---------------------------------------------------------------------------
package rct_pkg;

    // result kinds
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_CANCEL  = 3'd2;
    localparam logic [2:0] KIND_CMD_END = 3'd3;
    localparam logic [2:0] KIND_CMD_ERR = 3'd4;

    // number parse phases
    localparam logic [1:0] PH_BLANK  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [30:0] MAG31     = 31'h7FFF_FFFF;
    localparam logic [1:0]  SKIP_CNT  = 2'd2;
    localparam int          RES_SLOTS = 3;

    // number being read, plus the held-back carriage return
    typedef struct packed {
        logic [30:0] value;
        logic [1:0]  phase;
        logic        neg;
        logic        err;
        logic        cr;
    } num_t;

    typedef struct packed {
        num_t num;
        logic done;
    } line_t;

    // up to three results of one transaction
    typedef struct packed {
        logic [1:0]                   cnt;
        logic [RES_SLOTS-1:0][2:0]    kind;
        logic [RES_SLOTS-1:0][7:0]    data;
    } res_bundle_t;

    function automatic logic is_blank(logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    // accumulate one decimal digit with range check
    function automatic num_t num_digit(num_t n, logic [7:0] c);
        num_t        r;
        logic [34:0] v;
        logic [34:0] limit;
        r = n;
        v = ({4'd0, n.value} << 3) + ({4'd0, n.value} << 1) + {31'd0, c[3:0]};
        limit = n.neg ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;
        if (v > limit)
        begin
            r.err   = 1'b1;
            r.phase = PH_DONE;
        end
        else
        begin
            r.value = (v > {4'd0, MAG31}) ? MAG31 : v[30:0];
            r.phase = PH_DIGITS;
        end
        return r;
    endfunction

    // feed one character of number text
    function automatic num_t num_feed(num_t n, logic [7:0] c);
        num_t r;
        logic dig;
        r   = n;
        dig = (c >= CH_0) && (c <= CH_9);
        unique case (n.phase)
            PH_BLANK:
            begin
                if (is_blank(c))
                    r = n;
                else if ((c == CH_PLUS) || (c == CH_MINUS))
                begin
                    r.neg   = (c == CH_MINUS);
                    r.phase = PH_SIGN;
                end
                else if (dig)
                    r = num_digit(n, c);
                else
                begin
                    r.err   = 1'b1;
                    r.phase = PH_DONE;
                end
            end
            PH_SIGN:
            begin
                if (dig)
                    r = num_digit(n, c);
                else
                begin
                    r.err   = 1'b1;
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (dig)
                    r = num_digit(n, c);
                else
                    r.phase = PH_DONE;
            end
            PH_DONE:
                r = n;
        endcase
        return r;
    endfunction

    // one byte of a number line; done marks the closing cr lf
    function automatic line_t line_byte(num_t n, logic [7:0] c);
        line_t r;
        r.num  = n;
        r.done = 1'b0;
        if (n.cr)
        begin
            if (c == CH_LF)
            begin
                r.num.cr = 1'b0;
                r.done   = 1'b1;
            end
            else
            begin
                // lone cr counts as number text
                r.num = num_feed(n, CH_CR);
                if (c != CH_CR)
                begin
                    r.num.cr = 1'b0;
                    r.num    = num_feed(r.num, c);
                end
            end
        end
        else if (c == CH_CR)
            r.num.cr = 1'b1;
        else
            r.num = num_feed(n, c);
        return r;
    endfunction

endpackage

>>> rtl/rct_parser.sv
// ---------------------------------------------------------------------------
// rct_parser
// parse state registers and per-byte next state and result logic
// ---------------------------------------------------------------------------
module rct_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           in_byte,
    input  logic                 last_byte,
    output rct_pkg::res_bundle_t res
);

    typedef enum logic [3:0]
    {
        MODE_FIRST,
        MODE_GAP,
        MODE_WORD,
        MODE_COUNT,
        MODE_DOLLAR,
        MODE_LEN,
        MODE_DATA,
        MODE_SKIP,
        MODE_DONE,
        MODE_ERROR
    } mode_t;

    mode_t          mode_reg, mode_next;
    rct_pkg::num_t  num_reg, num_next;
    logic [30:0]    elements_reg, elements_next;
    logic [30:0]    bytes_reg, bytes_next;
    logic [1:0]     skip_reg, skip_next;

    // next state and results of one byte
    always_comb
    begin
        rct_pkg::line_t line;
        logic [30:0]    el_dec;
        logic [30:0]    by_dec;
        logic [1:0]     cnt;

        mode_next     = mode_reg;
        num_next      = num_reg;
        elements_next = elements_reg;
        bytes_next    = bytes_reg;
        skip_next     = skip_reg;
        res           = '0;
        cnt           = 2'd0;
        line          = rct_pkg::line_byte(num_reg, in_byte);
        el_dec        = elements_reg - 31'd1;
        by_dec        = bytes_reg - 31'd1;

        unique case (mode_reg)
            MODE_FIRST, MODE_GAP, MODE_WORD:
            begin
                if ((mode_reg == MODE_FIRST) && (in_byte == rct_pkg::CH_STAR))
                begin
                    num_next  = '0;
                    mode_next = MODE_COUNT;
                end
                else if (rct_pkg::is_blank(in_byte))
                begin
                    if (mode_reg == MODE_WORD)
                    begin
                        res.kind[cnt] = rct_pkg::KIND_END;
                        cnt = cnt + 2'd1;
                    end
                    mode_next = MODE_GAP;
                end
                else
                begin
                    res.kind[cnt] = rct_pkg::KIND_BYTE;
                    res.data[cnt] = in_byte;
                    cnt = cnt + 2'd1;
                    mode_next = MODE_WORD;
                end
            end
            MODE_COUNT:
            begin
                num_next = line.num;
                if (line.done)
                begin
                    if (line.num.err || (line.num.phase < rct_pkg::PH_DIGITS))
                        mode_next = MODE_ERROR;
                    else if (line.num.neg || (line.num.value == 31'd0))
                        mode_next = MODE_DONE;
                    else
                    begin
                        elements_next = line.num.value;
                        mode_next     = MODE_DOLLAR;
                    end
                end
            end
            MODE_DOLLAR:
            begin
                if (in_byte == rct_pkg::CH_DOLLAR)
                begin
                    num_next  = '0;
                    mode_next = MODE_LEN;
                end
                else
                    mode_next = MODE_DONE;
            end
            MODE_LEN:
            begin
                num_next = line.num;
                if (line.done)
                begin
                    if (line.num.err || (line.num.phase < rct_pkg::PH_DIGITS))
                        mode_next = MODE_ERROR;
                    else if (line.num.neg && (line.num.value != 31'd0))
                        mode_next = MODE_DONE;
                    else if (line.num.value == 31'd0)
                    begin
                        // empty token, then close the element
                        res.kind[cnt] = rct_pkg::KIND_END;
                        cnt = cnt + 2'd1;
                        elements_next = el_dec;
                        if (el_dec == 31'd0)
                            mode_next = MODE_DONE;
                        else
                        begin
                            skip_next = rct_pkg::SKIP_CNT;
                            mode_next = MODE_SKIP;
                        end
                    end
                    else
                    begin
                        bytes_next = line.num.value;
                        mode_next  = MODE_DATA;
                    end
                end
            end
            MODE_DATA:
            begin
                res.kind[cnt] = rct_pkg::KIND_BYTE;
                res.data[cnt] = in_byte;
                cnt = cnt + 2'd1;
                bytes_next = by_dec;
                if (by_dec == 31'd0)
                begin
                    res.kind[cnt] = rct_pkg::KIND_END;
                    cnt = cnt + 2'd1;
                    elements_next = el_dec;
                    if (el_dec == 31'd0)
                        mode_next = MODE_DONE;
                    else
                    begin
                        skip_next = rct_pkg::SKIP_CNT;
                        mode_next = MODE_SKIP;
                    end
                end
            end
            MODE_SKIP:
            begin
                skip_next = skip_reg - 2'd1;
                if (skip_next == 2'd0)
                    mode_next = MODE_DOLLAR;
            end
            default:
                mode_next = mode_reg;
        endcase

        // command end closes open tokens and resets the parse
        if (last_byte)
        begin
            if (mode_next == MODE_WORD)
            begin
                res.kind[cnt] = rct_pkg::KIND_END;
                cnt = cnt + 2'd1;
            end
            if ((mode_next == MODE_DATA) && (mode_reg == MODE_DATA))
            begin
                res.kind[cnt] = rct_pkg::KIND_CANCEL;
                cnt = cnt + 2'd1;
            end
            res.kind[cnt] = (mode_next == MODE_ERROR) ? rct_pkg::KIND_CMD_ERR
                                                      : rct_pkg::KIND_CMD_END;
            cnt = cnt + 2'd1;
            mode_next     = MODE_FIRST;
            num_next      = '0;
            elements_next = 31'd0;
            bytes_next    = 31'd0;
            skip_next     = 2'd0;
        end
        res.cnt = cnt;
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_FIRST;
            num_reg      <= '0;
            elements_reg <= 31'd0;
            bytes_reg    <= 31'd0;
            skip_reg     <= 2'd0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            num_reg      <= num_next;
            elements_reg <= elements_next;
            bytes_reg    <= bytes_next;
            skip_reg     <= skip_next;
        end
    end

endmodule

>>> rtl/rct_out_buf.sv
// ---------------------------------------------------------------------------
// rct_out_buf
// result register holding up to three results, drained one per transaction
// ---------------------------------------------------------------------------
module rct_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  rct_pkg::res_bundle_t res,
    output logic                 free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // out_byte
    output logic [2:0]           m_axis_tuser    // kind
);

    logic [1:0]                          cnt_reg;
    logic [rct_pkg::RES_SLOTS-1:0][2:0]  kind_reg;
    logic [rct_pkg::RES_SLOTS-1:0][7:0]  data_reg;
    logic                                pop;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = data_reg[0];
    assign m_axis_tuser  = kind_reg[0];
    assign pop           = m_axis_tvalid && m_axis_tready;

    // empty after this cycle
    assign free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= res.cnt;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // result slots, shifted toward the head on each transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
        end
        else if (pop)
        begin
            kind_reg[0] <= kind_reg[1];
            kind_reg[1] <= kind_reg[2];
            data_reg[0] <= data_reg[1];
            data_reg[1] <= data_reg[2];
        end
    end

endmodule

>>> rtl/resp_command_tokenizer_unit.sv
// ---------------------------------------------------------------------------
// resp_command_tokenizer_unit: byte stream command tokenizer
// path: byte in input register, parsed into the result register when that is free
// throughput: 1 byte per cycle unless the result register is still draining
// reset: rst_n clears parse state, input valid and result count at once
// ---------------------------------------------------------------------------
`include "resp_command_tokenizer_unit_macros.svh"

module resp_command_tokenizer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // in_byte
    input  logic       s_axis_tlast,    // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // out_byte
    output logic [2:0] m_axis_tuser     // kind
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 buf_free;
    logic                 parse_fire;
    rct_pkg::res_bundle_t res;

    assign parse_fire    = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || parse_fire;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    rct_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (parse_fire),
        .in_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    rct_out_buf u_out_buf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (parse_fire),
        .res           (res),
        .free          (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // a held byte stays put until the result register frees up
    `RCT_ASSERT_NEXT(a_in_hold, in_valid_reg && !parse_fire,
                     in_valid_reg && $stable(in_byte_reg), "input byte lost while stalled")

    // the last byte of a command always yields a command end or command error result
    `RCT_ASSERT_NEXT(a_last_result, parse_fire && in_last_reg, m_axis_tvalid,
                     "no result after last byte")

    // only defined kinds leave the block
    `RCT_ASSERT_ALWAYS(a_kind_range, !m_axis_tvalid || (m_axis_tuser <= rct_pkg::KIND_CMD_ERR),
                       "undefined result kind")

endmodule

>>> sim/tb_resp_command_tokenizer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_resp_command_tokenizer_unit
// self-checking bench for the command tokenizer: a clocked driver feeds
// command lines one byte per transaction, an in-bench tokenizer model
// predicts the output transactions, and a clocked monitor compares them.
// both sides insert random idle cycles
// ---------------------------------------------------------------------------
module tb_resp_command_tokenizer_unit;
    import rct_pkg::*;

    localparam int MAX_WAIT     = 18;
    localparam int RANDOM_BYTES = 75;
    localparam int DRAIN_CYCLES = 3 * (MAX_WAIT + 1) + 10;
    localparam int CYCLE_LIMIT  = 200000;

    // parser modes of the tokenizer model
    typedef enum logic [3:0] {
        M_FIRST, M_GAP, M_WORD, M_COUNT, M_DOLLAR,
        M_LEN, M_DATA, M_SKIP, M_DONE, M_ERROR
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cmd_byte_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } token_evt_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    // command bytes waiting to be sent, and token events waiting to arrive
    cmd_byte_t  byte_queue[$];
    token_evt_t expected_tokens[$];
    logic [7:0] cmd_q[$];

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int src_gap   = 0;
    int sink_stall = 0;
    int stall_now;
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int directed_n;
    cmd_byte_t nxt;

    // tokenizer model state
    parse_mode_t mode;
    logic [30:0] num_val;
    logic [1:0]  num_ph;
    logic        num_neg;
    logic        num_err;
    logic        cr_held;
    logic [30:0] elem_left;
    logic [30:0] data_left;
    logic [1:0]  skip_cnt;

    resp_command_tokenizer_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- tokenizer model ----------------

    function automatic logic is_ws(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic void put_token(input logic [2:0] k, input logic [7:0] d);
        token_evt_t e;
        e.kind = k;
        e.data = d;
        expected_tokens.insert(expected_tokens.size(), e);
    endfunction

    function automatic void num_reset();
        num_val = '0;
        num_ph  = PH_BLANK;
        num_neg = 1'b0;
        num_err = 1'b0;
        cr_held = 1'b0;
    endfunction

    function automatic void parser_reset();
        mode      = M_FIRST;
        num_reset();
        elem_left = '0;
        data_left = '0;
        skip_cnt  = '0;
    endfunction

    // decimal accumulate, out of int range flags an error
    function automatic void num_add_digit(input logic [7:0] c);
        logic [34:0] acc;
        logic [34:0] ceiling;
        acc     = {4'd0, num_val} * 35'd10 + {27'd0, c - CH_0};
        ceiling = num_neg ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;
        if (acc > ceiling)
        begin
            num_err = 1'b1;
            num_ph  = PH_DONE;
        end
        else
        begin
            num_val = (acc > 35'h0_7FFF_FFFF) ? MAG31 : acc[30:0];
            num_ph  = PH_DIGITS;
        end
    endfunction

    function automatic void num_feed_char(input logic [7:0] c);
        logic dig;
        dig = (c >= CH_0) && (c <= CH_9);
        case (num_ph)
            PH_BLANK:
            begin
                if (!is_ws(c))
                begin
                    if ((c == CH_PLUS) || (c == CH_MINUS))
                    begin
                        num_neg = (c == CH_MINUS);
                        num_ph  = PH_SIGN;
                    end
                    else if (dig)
                        num_add_digit(c);
                    else
                    begin
                        num_err = 1'b1;
                        num_ph  = PH_DONE;
                    end
                end
            end
            PH_SIGN:
            begin
                if (dig)
                    num_add_digit(c);
                else
                begin
                    num_err = 1'b1;
                    num_ph  = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (dig)
                    num_add_digit(c);
                else
                    num_ph = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // one byte of a number line, returns 1 on the closing cr lf
    function automatic logic num_line_char(input logic [7:0] c);
        logic done;
        done = 1'b0;
        if (cr_held)
        begin
            if (c == CH_LF)
            begin
                cr_held = 1'b0;
                done    = 1'b1;
            end
            else
            begin
                // a cr without lf is plain number text
                num_feed_char(CH_CR);
                if (c != CH_CR)
                begin
                    cr_held = 1'b0;
                    num_feed_char(c);
                end
            end
        end
        else if (c == CH_CR)
            cr_held = 1'b1;
        else
            num_feed_char(c);
        return done;
    endfunction

    function automatic logic num_invalid();
        return num_err || (num_ph < PH_DIGITS);
    endfunction

    function automatic void finish_element();
        elem_left = elem_left - 31'd1;
        if (elem_left == '0)
            mode = M_DONE;
        else
        begin
            skip_cnt = SKIP_CNT;
            mode     = M_SKIP;
        end
    endfunction

    // whitespace split of an inline command
    function automatic void split_char(input logic [7:0] c);
        if (is_ws(c))
        begin
            if (mode == M_WORD)
                put_token(KIND_END, 8'd0);
            mode = M_GAP;
        end
        else
        begin
            put_token(KIND_BYTE, c);
            mode = M_WORD;
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, input logic last);
        logic was_data;
        was_data = (mode == M_DATA);
        case (mode)
            M_FIRST:
            begin
                if (c == CH_STAR)
                begin
                    num_reset();
                    mode = M_COUNT;
                end
                else
                    split_char(c);
            end
            M_GAP, M_WORD:
                split_char(c);
            M_COUNT:
            begin
                if (num_line_char(c))
                begin
                    if (num_invalid())
                        mode = M_ERROR;
                    else if ((num_neg && (num_val != '0)) || (num_val == '0))
                        mode = M_DONE;
                    else
                    begin
                        elem_left = num_val;
                        mode      = M_DOLLAR;
                    end
                end
            end
            M_DOLLAR:
            begin
                if (c == CH_DOLLAR)
                begin
                    num_reset();
                    mode = M_LEN;
                end
                else
                    mode = M_DONE;
            end
            M_LEN:
            begin
                if (num_line_char(c))
                begin
                    if (num_invalid())
                        mode = M_ERROR;
                    else if (num_neg && (num_val != '0))
                        mode = M_DONE;
                    else if (num_val == '0)
                    begin
                        put_token(KIND_END, 8'd0);
                        finish_element();
                    end
                    else
                    begin
                        data_left = num_val;
                        mode      = M_DATA;
                    end
                end
            end
            M_DATA:
            begin
                put_token(KIND_BYTE, c);
                data_left = data_left - 31'd1;
                if (data_left == '0)
                begin
                    put_token(KIND_END, 8'd0);
                    finish_element();
                end
            end
            M_SKIP:
            begin
                skip_cnt = skip_cnt - 2'd1;
                if (skip_cnt == '0)
                    mode = M_DOLLAR;
            end
            default: ;
        endcase

        // end of the command line
        if (last)
        begin
            if (mode == M_WORD)
                put_token(KIND_END, 8'd0);
            if ((mode == M_DATA) && was_data)
                put_token(KIND_CANCEL, 8'd0);
            put_token((mode == M_ERROR) ? KIND_CMD_ERR : KIND_CMD_END, 8'd0);
            parser_reset();
        end
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cmd_q.insert(cmd_q.size(), s[i]);
    endfunction

    function automatic void add_crlf();
        cmd_q.insert(cmd_q.size(), CH_CR);
        cmd_q.insert(cmd_q.size(), CH_LF);
    endfunction

    // move the first keep bytes of the command to the send queue
    function automatic void emit_command(input int keep);
        cmd_byte_t item;
        for (int i = 0; i < keep; i++)
        begin
            item.data = cmd_q[i];
            item.last = (i == keep - 1);
            byte_queue.insert(byte_queue.size(), item);
        end
        cmd_q.delete();
    endfunction

    // number line text for value v, mostly well formed
    function automatic void add_number(input int v);
        int    pick;
        string s;
        pick = $urandom_range(0, 19);
        case (pick)
            12:
            begin
                add_text($sformatf("%0d", v));
                add_text("x");
            end
            13:
            begin
                // lone cr ends the digits
                add_text($sformatf("%0d", v));
                cmd_q.insert(cmd_q.size(), CH_CR);
                add_text("7");
            end
            14:
            begin
                case ($urandom_range(0, 5))
                    0:       s = "2147483647";
                    1:       s = "2147483648";
                    2:       s = "-2147483648";
                    3:       s = "-2147483649";
                    4:       s = "99999999999";
                    default: s = "-0";
                endcase
                add_text(s);
            end
            15:
            begin
                case ($urandom_range(0, 4))
                    0:       s = "";
                    1:       s = "x";
                    2:       s = "-";
                    3:       s = "+ 1";
                    default: s = " -";
                endcase
                add_text(s);
            end
            16:
                add_text($sformatf("-%0d", v + 1));
            17:
            begin
                // cr cr lf
                add_text($sformatf("%0d", v));
                cmd_q.insert(cmd_q.size(), CH_CR);
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    cmd_q.insert(cmd_q.size(), $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                if ($urandom_range(0, 4) == 0)
                    cmd_q.insert(cmd_q.size(), CH_PLUS);
                if ($urandom_range(0, 4) == 0)
                    cmd_q.insert(cmd_q.size(), CH_0);
                add_text($sformatf("%0d", v));
            end
        endcase
        add_crlf();
    endfunction

    function automatic void gen_command();
        int sel;
        int cnt;
        int len;
        int keep;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            // inline command split on whitespace
            cnt = $urandom_range(1, 10);
            for (int i = 0; i < cnt; i++)
            begin
                if ($urandom_range(0, 9) < 4)
                    cmd_q.insert(cmd_q.size(),
                                 ($urandom_range(0, 5) == 5) ? CH_SPACE
                                                             : 8'($urandom_range(9, 13)));
                else
                    cmd_q.insert(cmd_q.size(), 8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // array of bulk strings
            cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            cmd_q.insert(cmd_q.size(), CH_STAR);
            add_number(cnt);
            for (int e = 0; e < cnt; e++)
            begin
                cmd_q.insert(cmd_q.size(),
                             ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                          : CH_DOLLAR);
                len = $urandom_range(0, 5);
                add_number(len);
                for (int j = 0; j < len; j++)
                    cmd_q.insert(cmd_q.size(), 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0)
                begin
                    cmd_q.insert(cmd_q.size(), 8'($urandom_range(0, 255)));
                    cmd_q.insert(cmd_q.size(), 8'($urandom_range(0, 255)));
                end
                else
                    add_crlf();
            end
        end
        keep = (sel < 70) ? cmd_q.size() : $urandom_range(1, cmd_q.size());
        emit_command(keep);
    endfunction

    // ---------------- checking ----------------

    function automatic void check_token(input logic [2:0] k, input logic [7:0] d);
        token_evt_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("unexpected transaction: kind %0d out_byte 0x%02h", k, d);
            err_cnt++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (want.kind !== k)
            begin
                $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
                err_cnt++;
            end
            if (want.data !== d)
            begin
                $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data, d);
                err_cnt++;
            end
        end
    endfunction

    // driver: one command byte per transaction, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            s_axis_tlast  <= 1'b0;
            src_gap       <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                tokenize_byte(s_axis_tdata, s_axis_tlast);
            if (src_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_gap       <= src_gap - 1;
            end
            else if (byte_queue.size() != 0)
            begin
                nxt = byte_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tlast  <= nxt.last;
                if ($urandom_range(0, 15) == 0)
                    src_calm = !src_calm;
                src_gap <= src_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: check each output transaction, random stall after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end
        else
        begin
            stall_now = sink_stall;
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_token(m_axis_tuser, m_axis_tdata);
                if ($urandom_range(0, 15) == 0)
                    sink_calm = !sink_calm;
                stall_now = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (stall_now != 0)
            begin
                m_axis_tready <= 1'b0;
                sink_stall    <= stall_now - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_stall    <= 0;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        parser_reset();

        // inline tokens with the extreme byte values
        cmd_q.insert(cmd_q.size(), 8'hFF);
        cmd_q.insert(cmd_q.size(), CH_SPACE);
        cmd_q.insert(cmd_q.size(), 8'h00);
        emit_command(cmd_q.size());

        // one zero length element
        cmd_q.insert(cmd_q.size(), CH_STAR);
        add_text("1");
        add_crlf();
        cmd_q.insert(cmd_q.size(), CH_DOLLAR);
        add_text("0");
        add_crlf();
        emit_command(cmd_q.size());

        // count with no digits
        cmd_q.insert(cmd_q.size(), CH_STAR);
        add_text("x");
        add_crlf();
        emit_command(cmd_q.size());

        // token cut short by the end of the command
        cmd_q.insert(cmd_q.size(), CH_STAR);
        add_text("1");
        add_crlf();
        cmd_q.insert(cmd_q.size(), CH_DOLLAR);
        add_text("3");
        add_crlf();
        add_text("ab");
        emit_command(cmd_q.size());

        directed_n = byte_queue.size();
        while (byte_queue.size() < directed_n + RANDOM_BYTES)
            gen_command();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while ((byte_queue.size() != 0) || s_axis_tvalid || (expected_tokens.size() != 0));
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected transactions never arrived", expected_tokens.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
